// ----- hw/rtl/slfe_pkg.sv -----
// Shared types and constants for the SLIP frame encoder.
// Holds byte codes, operation and mode codes and the per-request result record.
// No dependencies; imported by slfe_step and slip_frame_encoder_core.
package slfe_pkg;

    // SLIP special bytes
    localparam logic [7:0] BYTE_END     = 8'hC0;
    localparam logic [7:0] BYTE_ESC     = 8'hDB;
    localparam logic [7:0] BYTE_ESC_END = 8'hDC;
    localparam logic [7:0] BYTE_ESC_ESC = 8'hDD;

    localparam int          MAX_RESULTS   = 3;
    localparam logic [15:0] BUF_SIZE_RST  = 16'd1024;

    typedef enum logic [1:0] {
        OP_QUEUE_BYTE = 2'd0,
        OP_MSG_START  = 2'd1,
        OP_MSG_DONE   = 2'd2,
        OP_BUF_RESET  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_NOMINAL = 2'd0,
        MODE_END     = 2'd1,
        MODE_ESC_ESC = 2'd2,
        MODE_ESC_END = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_INCOMPLETE = 2'd2
    } status_t;

    // Everything one request produces, plus the encoder's next state
    typedef struct packed {
        mode_t                            mode_next;
        logic [15:0]                      fill_next;
        logic [1:0]                       n_bytes;
        logic [MAX_RESULTS-1:0][7:0]      bytes;
        logic [MAX_RESULTS-1:0][15:0]     idx;
        status_t                          status;
    } step_res_t;

endpackage

// ----- hw/rtl/slfe_step.sv -----
// Combinational encode step: one request against the current mode and fill.
// Produces up to three buffer writes, the status and the next encoder state.
// Depends on slfe_pkg.
module slfe_step import slfe_pkg::*; (
    input  op_t         op,
    input  logic [7:0]  data_byte,
    input  mode_t       mode,
    input  logic [15:0] fill,
    input  logic [15:0] buf_size,
    output step_res_t   res
);

    always_comb begin
        mode_t       m;
        logic [15:0] f;
        logic [1:0]  n;
        logic        done;
        status_t     st;

        m    = mode;
        f    = fill;
        n    = 2'd0;
        done = 1'b0;
        st   = ST_OK;
        res.bytes = '0;
        res.idx   = '0;

        case (op)
            OP_QUEUE_BYTE: begin
                // walk at most three emit steps: pending END, escape lead, final byte
                for (int i = 0; i < MAX_RESULTS; i++) begin
                    if (!done) begin
                        if (f >= buf_size) begin
                            done = 1'b1;
                            st   = ST_INCOMPLETE;
                        end else begin
                            res.idx[n] = f;
                            case (m)
                                MODE_NOMINAL: begin
                                    if (data_byte == BYTE_END) begin
                                        res.bytes[n] = BYTE_ESC;
                                        m = MODE_ESC_END;
                                    end else if (data_byte == BYTE_ESC) begin
                                        res.bytes[n] = BYTE_ESC;
                                        m = MODE_ESC_ESC;
                                    end else begin
                                        res.bytes[n] = data_byte;
                                        done = 1'b1;
                                    end
                                end
                                MODE_END: begin
                                    res.bytes[n] = BYTE_END;
                                    m = MODE_NOMINAL;
                                end
                                MODE_ESC_ESC: begin
                                    res.bytes[n] = BYTE_ESC_ESC;
                                    m = MODE_NOMINAL;
                                    done = 1'b1;
                                end
                                default: begin
                                    res.bytes[n] = BYTE_ESC_END;
                                    m = MODE_NOMINAL;
                                    done = 1'b1;
                                end
                            endcase
                            f = f + 16'd1;
                            n = n + 2'd1;
                            // completed write: flag a buffer that is now full
                            if (done) begin
                                st = (f >= buf_size) ? ST_FULL : ST_OK;
                            end
                        end
                    end
                end
            end
            OP_MSG_START: begin
                m = MODE_NOMINAL;
            end
            OP_MSG_DONE: begin
                if (f >= buf_size) begin
                    m  = MODE_END;
                    st = ST_INCOMPLETE;
                end else begin
                    res.bytes[0] = BYTE_END;
                    res.idx[0]   = f;
                    f = f + 16'd1;
                    n = 2'd1;
                    m = MODE_NOMINAL;
                end
            end
            default: begin
                f = 16'd0;
            end
        endcase

        res.mode_next = m;
        res.fill_next = f;
        res.n_bytes   = n;
        res.status    = st;
    end

endmodule

// ----- hw/rtl/slip_frame_encoder_core.sv -----
// SLIP frame encoder top level: input stream, result stream, size register.
// Depends on slfe_pkg and slfe_step.
//
// Usage:
//   s_* carries requests: s_tuser is the operation (queue byte, message start,
//   message complete, buffer reset), s_tdata the payload byte.
//   m_* carries one result per buffer write, in order, with m_tlast on the
//   final result of each request; the status is valid on that result.
//   A request that writes nothing still gives one result with has_byte low.
//   cfg_* writes the buffer size; cfg_ready is always high. Write it only
//   while no results are outstanding.
// Timing:
//   A request's results are registered: the first shows in the cycle after it is accepted.
//   A request gives 1 to 3 results: the result register serializes them one
//   per cycle while m_tready is high, and the next request is taken in the
//   same cycle as the final result of the previous one.
// Reset and stall:
//   aresetn low clears the mode, fill count, size (1024) and result control, not the payload.
//   While a result waits on a low m_tready it holds and s_tready stays low.
module slip_frame_encoder_core import slfe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,     // [15:0] buffer_size
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] data_byte
    input  logic [1:0]  s_tuser,      // [1:0] operation
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // [7:0] out_byte, [23:8] byte_index,
                                      // [25:24] status, [31:26] zero
    output logic [0:0]  m_tuser,      // [0] has_byte
    output logic        m_tlast
);

    logic [15:0] buf_size_reg;
    mode_t       mode_reg;
    logic [15:0] fill_reg;

    logic                         busy_reg;
    logic [1:0]                   rd_ptr_reg;
    logic [1:0]                   cnt_reg;
    logic                         has_reg;
    logic [MAX_RESULTS-1:0][7:0]  bytes_reg;
    logic [MAX_RESULTS-1:0][15:0] idx_reg;
    status_t                      status_reg;

    step_res_t res;
    logic      s_accept;
    logic      m_take;
    logic      last_entry;

    // encode the incoming request against the current state
    slfe_step u_step (
        .op        (op_t'(s_tuser)),
        .data_byte (s_tdata),
        .mode      (mode_reg),
        .fill      (fill_reg),
        .buf_size  (buf_size_reg),
        .res       (res)
    );

    assign cfg_ready  = 1'b1;
    assign last_entry = (rd_ptr_reg == (cnt_reg - 2'd1));
    assign m_take     = m_tvalid && m_tready;
    assign s_tready   = !busy_reg || (m_tready && last_entry);
    assign s_accept   = s_tvalid && s_tready;

    // hold size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_size_reg <= BUF_SIZE_RST;
        end else if (cfg_valid && cfg_ready) begin
            buf_size_reg <= cfg_data;
        end
    end

    // advance encoder state on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NOMINAL;
            fill_reg <= 16'd0;
        end else if (s_accept) begin
            mode_reg <= res.mode_next;
            fill_reg <= res.fill_next;
        end
    end

    // result buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 2'd1;
        end else if (s_accept) begin
            busy_reg   <= 1'b1;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= (res.n_bytes == 2'd0) ? 2'd1 : res.n_bytes;
        end else if (m_take && last_entry) begin
            busy_reg <= 1'b0;
        end else if (m_take) begin
            rd_ptr_reg <= rd_ptr_reg + 2'd1;
        end
    end

    // result payload, loaded once per request
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            has_reg    <= (res.n_bytes != 2'd0);
            bytes_reg  <= res.bytes;
            idx_reg    <= res.idx;
            status_reg <= res.status;
        end
    end

    // drive the current entry; status only on the final one
    assign m_tvalid   = busy_reg;
    assign m_tlast    = last_entry;
    assign m_tuser[0] = has_reg;
    assign m_tdata    = {6'd0,
                         last_entry ? status_reg : ST_OK,
                         has_reg ? idx_reg[rd_ptr_reg] : 16'd0,
                         has_reg ? bytes_reg[rd_ptr_reg] : 8'd0};

    // read pointer stays inside the loaded results
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rd_ptr_reg < cnt_reg))
        else $error("result read pointer beyond result count");

    // an accepted request always presents a result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (m_tvalid && rd_ptr_reg == 2'd0))
        else $error("accepted request produced no result");

    // fill count moves only with an accepted request
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(fill_reg))
        else $error("fill count changed without a request");

    // a result without a byte is always the only, final result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && cnt_reg == 2'd1))
        else $error("empty result not final");

endmodule
